// ===== design/tlc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the two-level LRU cache timing block.
// No dependencies.
package tlc_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_INSTR_HIT  = 3'd0;
    localparam logic [2:0] CFG_DATA_HIT   = 3'd1;
    localparam logic [2:0] CFG_L2_HIT     = 3'd2;
    localparam logic [2:0] CFG_MEM_LAT    = 3'd3;
    localparam logic [2:0] CFG_INCLUSIVE  = 3'd4;
    localparam logic [2:0] CFG_BLOCK_BITS = 3'd5;
    localparam logic [2:0] CFG_ENABLE     = 3'd6;

    localparam int CFG_DATA_W = 10;
    localparam int TIME_W     = 11;
    localparam int CLR_W      = 14;

    // lookup outcome of one cache level
    typedef struct packed {
        logic        hit;
        logic        evict;
        logic [31:0] ev_addr;
    } lvl_res_t;

endpackage

// ===== design/tlc_req_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces.
// Depends on nothing.
interface tlc_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] address;
    modport source (output valid, output kind, output address, input ready);
    modport sink (input valid, input kind, input address, output ready);
endinterface

interface tlc_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] access_time;
    logic        first_level_hit;
    logic        second_level_used;
    logic        second_level_hit;
    modport source (output valid, output access_time, output first_level_hit,
                    output second_level_used, output second_level_hit, input ready);
    modport sink (input valid, input access_time, input first_level_hit,
                  input second_level_used, input second_level_hit, output ready);
endinterface

// ===== design/tlc_level.sv =====
`timescale 1ns / 1ps
// One set-associative cache level: row memory of valid, rank and tag per way,
// true-LRU lookup/fill, back-invalidate and reset sweep. Uses tlc_pkg.
module tlc_level #(
    parameter int SETS = 256,
    parameter int WAYS = 4
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [31:0]              rd_addr,
    input  logic [3:0]               bob,
    input  logic                     acc_en,
    input  logic                     inv_en,
    input  logic                     clr_en,
    input  logic [tlc_pkg::CLR_W-1:0] clr_idx,
    output tlc_pkg::lvl_res_t        res
);
    import tlc_pkg::*;

    localparam int SB    = $clog2(SETS);
    localparam int IB    = (SB > 0) ? SB : 1;
    localparam int RB    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TW    = 32 - SB;
    localparam int SW    = 1 + RB + TW;
    localparam int ROW_W = WAYS * SW;

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] row_q;
    logic [31:0]      addr_reg;

    logic [31:0]   rd_sh, cur_sh, tag_full;
    logic [IB-1:0] rd_idx, cur_idx, wr_idx;
    logic [5:0]    shamt;
    logic [TW-1:0] cur_tag;

    logic [WAYS-1:0] v;
    logic [RB-1:0]   rk [WAYS];
    logic [TW-1:0]   tg [WAYS];

    logic            hit, found;
    logic [RB-1:0]   hw, vic, way, r;
    logic [ROW_W-1:0] acc_row, inv_row, clr_row, wr_row;
    logic            wr_en;

    always_comb
    begin
        rd_sh    = rd_addr >> bob;
        cur_sh   = addr_reg >> bob;
        rd_idx   = (SETS > 1) ? rd_sh[IB-1:0] : '0;
        cur_idx  = (SETS > 1) ? cur_sh[IB-1:0] : '0;
        shamt    = {2'b00, bob} + 6'(SB);
        tag_full = addr_reg >> shamt;
        cur_tag  = tag_full[TW-1:0];
    end

    always_comb
    begin
        for (int j = 0; j < WAYS; j++)
        begin
            v[j]  = row_q[j*SW];
            rk[j] = row_q[j*SW+1 +: RB];
            tg[j] = row_q[j*SW+1+RB +: TW];
        end
        hit = 1'b0;
        hw  = '0;
        for (int j = 0; j < WAYS; j++)
        begin
            if (!hit && v[j] && tg[j] == cur_tag)
            begin
                hit = 1'b1;
                hw  = RB'(j);
            end
        end
        found = 1'b0;
        vic   = '0;
        for (int j = 0; j < WAYS; j++)
        begin
            if (!found && !v[j])
            begin
                found = 1'b1;
                vic   = RB'(j);
            end
        end
        if (!found)
        begin
            for (int j = 1; j < WAYS; j++)
            begin
                if (rk[j] > rk[vic])
                    vic = RB'(j);
            end
        end
        way = hit ? hw : vic;
        r   = rk[way];
        acc_row = row_q;
        inv_row = row_q;
        clr_row = '0;
        for (int j = 0; j < WAYS; j++)
        begin
            // promote: younger entries age by one, touched way becomes newest
            if (RB'(j) == way)
                acc_row[j*SW+1 +: RB] = '0;
            else if (rk[j] < r)
                acc_row[j*SW+1 +: RB] = rk[j] + 1'b1;
            if (!hit && RB'(j) == way)
            begin
                acc_row[j*SW] = 1'b1;
                acc_row[j*SW+1+RB +: TW] = cur_tag;
            end
            if (hit && RB'(j) == hw)
                inv_row[j*SW] = 1'b0;
            clr_row[j*SW+1 +: RB] = RB'(j);
        end
        res.hit     = hit;
        res.evict   = !hit && !found;
        res.ev_addr = (32'(tg[vic]) << shamt) + (32'(cur_idx) << bob);
    end

    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = cur_idx;
        wr_row = acc_row;
        if (clr_en)
        begin
            wr_en  = ({1'b0, clr_idx} < (CLR_W+1)'(SETS));
            wr_idx = (SETS > 1) ? clr_idx[IB-1:0] : '0;
            wr_row = clr_row;
        end
        else if (acc_en)
        begin
            wr_en = 1'b1;
        end
        else if (inv_en)
        begin
            wr_en  = 1'b1;
            wr_row = inv_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= wr_row;
        if (rd_en)
        begin
            row_q    <= mem[rd_idx];
            addr_reg <= rd_addr;
        end
    end

endmodule

// ===== design/two_level_lru_cache_timing.sv =====
`timescale 1ns / 1ps
// Two-level LRU cache timing model: instruction and data L1 plus shared L2.
// Each accepted item runs a read-modify-write sequence on the row memories:
// states L1 and L2, plus INVR and INV when an inclusive L2 eviction
// back-invalidates the L1s, then DONE, which registers the result once the
// previous one is taken; the next item is taken only in idle. After reset, a
// clearing pass over max(INSTR_SETS, DATA_SETS, SECOND_SETS) sets runs first.
// Uses tlc_pkg, tlc_req_if/tlc_rsp_if and tlc_level.
module two_level_lru_cache_timing #(
    parameter int INSTR_SETS  = 256,
    parameter int INSTR_WAYS  = 4,
    parameter int DATA_SETS   = 256,
    parameter int DATA_WAYS   = 4,
    parameter int SECOND_SETS = 1024,
    parameter int SECOND_WAYS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tlc_req_if.sink                       req,
    tlc_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [tlc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tlc_pkg::*;

    localparam int MAX_A = (INSTR_SETS > DATA_SETS) ? INSTR_SETS : DATA_SETS;
    localparam int MAXS  = (MAX_A > SECOND_SETS) ? MAX_A : SECOND_SETS;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_L1    = 7'b0000100,
        S_L2    = 7'b0001000,
        S_INVR  = 7'b0010000,
        S_INV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0] ihit_reg, dhit_reg, l2hit_t_reg;
    logic [9:0] mem_lat_reg;
    logic       incl_reg;
    logic [3:0] bob_reg;
    logic [2:0] mask_reg;

    logic [CLR_W-1:0]  clr_reg, clr_next;
    logic              kind_reg, kind_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic              l1hit_reg, l1hit_next;
    logic              l2used_reg, l2used_next;
    logic              l2hit_reg, l2hit_next;
    logic [31:0]       ev_reg, ev_next;

    logic              rv_reg, rv_next;
    logic [TIME_W-1:0] rtime_reg, rtime_next;
    logic              rl1_reg, rl1_next, ru_reg, ru_next, rl2_reg, rl2_next;

    lvl_res_t i_res, d_res, s_res, l1_res;
    logic     accept, l1_on;
    logic     i_rd, d_rd, i_acc, d_acc, s_acc, i_inv, d_inv, clr_en;
    logic [31:0] l1_addr;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign clr_en    = (state_reg == S_CLEAR);
    assign l1_on     = kind_reg ? mask_reg[1] : mask_reg[0];
    assign l1_res    = kind_reg ? d_res : i_res;
    assign l1_addr   = (state_reg == S_INVR) ? ev_reg : req.address;
    assign i_rd      = (accept && !req.kind) || (state_reg == S_INVR);
    assign d_rd      = (accept && req.kind) || (state_reg == S_INVR);
    assign i_acc     = (state_reg == S_L1) && l1_on && !kind_reg;
    assign d_acc     = (state_reg == S_L1) && l1_on && kind_reg;
    assign s_acc     = (state_reg == S_L2) && l2used_reg && mask_reg[2];
    assign i_inv     = (state_reg == S_INV) && mask_reg[0];
    assign d_inv     = (state_reg == S_INV) && mask_reg[1];

    tlc_level #(.SETS(INSTR_SETS), .WAYS(INSTR_WAYS)) u_instr (
        .clk(clk), .rd_en(i_rd), .rd_addr(l1_addr), .bob(bob_reg),
        .acc_en(i_acc), .inv_en(i_inv), .clr_en(clr_en), .clr_idx(clr_reg),
        .res(i_res)
    );

    tlc_level #(.SETS(DATA_SETS), .WAYS(DATA_WAYS)) u_data (
        .clk(clk), .rd_en(d_rd), .rd_addr(l1_addr), .bob(bob_reg),
        .acc_en(d_acc), .inv_en(d_inv), .clr_en(clr_en), .clr_idx(clr_reg),
        .res(d_res)
    );

    tlc_level #(.SETS(SECOND_SETS), .WAYS(SECOND_WAYS)) u_second (
        .clk(clk), .rd_en(accept), .rd_addr(req.address), .bob(bob_reg),
        .acc_en(s_acc), .inv_en(1'b0), .clr_en(clr_en), .clr_idx(clr_reg),
        .res(s_res)
    );

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        kind_next   = kind_reg;
        time_next   = time_reg;
        l1hit_next  = l1hit_reg;
        l2used_next = l2used_reg;
        l2hit_next  = l2hit_reg;
        ev_next     = ev_reg;
        rv_next     = rv_reg && !rsp.ready;
        rtime_next  = rtime_reg;
        rl1_next    = rl1_reg;
        ru_next     = ru_reg;
        rl2_next    = rl2_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(MAXS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = req.kind;
                    state_next = S_L1;
                end
            end
            S_L1:
            begin
                time_next   = l1_on ? TIME_W'(kind_reg ? dhit_reg : ihit_reg) : '0;
                l1hit_next  = l1_on && l1_res.hit;
                l2used_next = !(l1_on && l1_res.hit);
                l2hit_next  = 1'b0;
                state_next  = S_L2;
            end
            S_L2:
            begin
                state_next = S_DONE;
                if (l2used_reg)
                begin
                    if (mask_reg[2])
                    begin
                        l2hit_next = s_res.hit;
                        if (s_res.hit)
                            time_next = time_reg + TIME_W'(l2hit_t_reg);
                        else
                            time_next = time_reg + TIME_W'(l2hit_t_reg)
                                        + TIME_W'(mem_lat_reg);
                        if (!s_res.hit && s_res.evict && incl_reg)
                        begin
                            ev_next    = s_res.ev_addr;
                            state_next = S_INVR;
                        end
                    end
                    else
                    begin
                        time_next = time_reg + TIME_W'(mem_lat_reg);
                    end
                end
            end
            S_INVR:
            begin
                state_next = S_INV;
            end
            S_INV:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rv_reg || rsp.ready)
                begin
                    rv_next    = 1'b1;
                    rtime_next = time_reg;
                    rl1_next   = l1hit_reg;
                    ru_next    = l2used_reg;
                    rl2_next   = l2hit_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            rv_reg      <= 1'b0;
            ihit_reg    <= 8'd1;
            dhit_reg    <= 8'd1;
            l2hit_t_reg <= 8'd10;
            mem_lat_reg <= 10'd100;
            incl_reg    <= 1'b0;
            bob_reg     <= 4'd6;
            mask_reg    <= 3'd7;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_INSTR_HIT:  ihit_reg    <= cfg_data[7:0];
                    CFG_DATA_HIT:   dhit_reg    <= cfg_data[7:0];
                    CFG_L2_HIT:     l2hit_t_reg <= cfg_data[7:0];
                    CFG_MEM_LAT:    mem_lat_reg <= cfg_data[9:0];
                    CFG_INCLUSIVE:  incl_reg    <= cfg_data[0];
                    CFG_BLOCK_BITS: bob_reg     <= cfg_data[3:0];
                    CFG_ENABLE:     mask_reg    <= cfg_data[2:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        time_reg   <= time_next;
        l1hit_reg  <= l1hit_next;
        l2used_reg <= l2used_next;
        l2hit_reg  <= l2hit_next;
        ev_reg     <= ev_next;
        rtime_reg  <= rtime_next;
        rl1_reg    <= rl1_next;
        ru_reg     <= ru_next;
        rl2_reg    <= rl2_next;
    end

    assign rsp.valid             = rv_reg;
    assign rsp.access_time       = rtime_reg;
    assign rsp.first_level_hit   = rl1_reg;
    assign rsp.second_level_used = ru_reg;
    assign rsp.second_level_hit  = rl2_reg;

endmodule

// ===== design/tlc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for two_level_lru_cache_timing, attached by bind.
// Depends on the top level's port names only.
module tlc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [10:0] rsp_time,
    input logic        rsp_l1,
    input logic        rsp_used,
    input logic        rsp_l2
);
    // a waiting item stays valid and keeps its access time
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_time))
        else $error("response changed while stalled");

    a_l1_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_l1 && rsp_used))
        else $error("L1 hit but L2 path used");

    a_l2_needs_use: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_l2 |-> rsp_used)
        else $error("L2 hit without L2 path");

    a_l1_no_l2: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_l1 |-> !rsp_l2)
        else $error("L1 and L2 hit together");
endmodule

bind two_level_lru_cache_timing tlc_checker u_tlc_checker (
    .clk(clk), .rst_n(rst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_time(rsp.access_time), .rsp_l1(rsp.first_level_hit),
    .rsp_used(rsp.second_level_used), .rsp_l2(rsp.second_level_hit)
);
